// File: design/pll_pkg.sv
`timescale 1ns / 1ps

package pll_pkg;

  // Field and datapath widths
  localparam int unsigned NfW      = 7;   // num_features register
  localparam int unsigned CoefIdxW = 6;   // coefficient slot index
  localparam int unsigned ValueW   = 16;  // Q4.12 feature / coefficient
  localparam int unsigned ProdW    = 32;  // Q8.24 product
  localparam int unsigned AccW     = 40;  // Q16.24 dot product, saturating
  localparam int unsigned AccSumW  = AccW + 1;
  localparam int unsigned ZShift   = 12;  // Q16.24 -> Q4.12
  localparam int unsigned ZW       = 16;  // Q4.12 linear predictor
  localparam int unsigned LlW      = 19;  // Q7.12 log-likelihood
  localparam int unsigned TotW     = 36;  // Q24.12 running total
  localparam int unsigned TotSumW  = TotW + 1;

  localparam logic signed [ZW-1:0] ZMin = 16'sh8000;
  localparam logic signed [ZW-1:0] ZMax = 16'sh7fff;

  // Item kinds on the input channel
  typedef enum logic {
    OpData = 1'b0,
    OpLoad = 1'b1
  } op_e;

  // ---------------------------------------------------------------------
  // Elaboration-time fixed point math for the log Phi table.
  // Signed values with 40 fraction bits in 64-bit words.
  // ---------------------------------------------------------------------
  localparam int unsigned Frac = 40;
  localparam longint One     = 64'sh0000_0100_0000_0000;
  localparam longint OdeStep = One >>> 7;

  // Integration state: abscissa and Mills ratio
  typedef struct packed {
    logic signed [63:0] t;
    logic signed [63:0] m;
  } ode_t;

  function automatic logic [63:0] fx_mag(longint a);
    logic [63:0] ua;
    ua = a;
    if (a < 0) ua = 64'd0 - ua;
    return ua;
  endfunction

  // Product rounded half away from zero
  function automatic longint fx_mul(longint a, longint b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [63:0]  r;
    ua = fx_mag(a);
    ub = fx_mag(b);
    p  = 128'(ua) * 128'(ub) + (128'd1 << (Frac - 1));
    r  = p[Frac +: 64];
    if ((a < 0) != (b < 0)) return -$signed(r);
    return $signed(r);
  endfunction

  // Quotient of nonnegative values, truncated, by long division
  function automatic longint fx_div(logic [63:0] a, logic [63:0] b);
    logic [64:0] rw;
    logic [63:0] q;
    logic [63:0] r;
    int          i;
    if (b == 64'd0) return 0;
    rw = '0;
    q  = '0;
    for (i = 63; i >= 0; i--) begin
      rw = {rw[63:0], a[i]};
      if (rw >= {1'b0, b}) begin
        rw   = rw - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    r = rw[63:0];
    for (i = 0; i < Frac; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r    = r - b;
        q[0] = 1'b1;
      end
    end
    return $signed(q);
  endfunction

  // Division by a small series index, truncated toward zero
  function automatic longint fx_div_small(longint x, logic [5:0] n);
    longint q;
    case (n)
      6'd1:  q = x / 64'sd1;
      6'd2:  q = x / 64'sd2;
      6'd3:  q = x / 64'sd3;
      6'd4:  q = x / 64'sd4;
      6'd5:  q = x / 64'sd5;
      6'd6:  q = x / 64'sd6;
      6'd7:  q = x / 64'sd7;
      6'd8:  q = x / 64'sd8;
      6'd9:  q = x / 64'sd9;
      6'd10: q = x / 64'sd10;
      6'd11: q = x / 64'sd11;
      6'd12: q = x / 64'sd12;
      6'd13: q = x / 64'sd13;
      6'd14: q = x / 64'sd14;
      6'd15: q = x / 64'sd15;
      6'd16: q = x / 64'sd16;
      6'd17: q = x / 64'sd17;
      6'd18: q = x / 64'sd18;
      6'd19: q = x / 64'sd19;
      6'd20: q = x / 64'sd20;
      6'd21: q = x / 64'sd21;
      6'd22: q = x / 64'sd22;
      6'd23: q = x / 64'sd23;
      6'd24: q = x / 64'sd24;
      6'd25: q = x / 64'sd25;
      6'd26: q = x / 64'sd26;
      6'd27: q = x / 64'sd27;
      6'd28: q = x / 64'sd28;
      6'd29: q = x / 64'sd29;
      6'd30: q = x / 64'sd30;
      6'd31: q = x / 64'sd31;
      6'd33: q = x / 64'sd33;
      6'd35: q = x / 64'sd35;
      6'd37: q = x / 64'sd37;
      6'd39: q = x / 64'sd39;
      6'd41: q = x / 64'sd41;
      6'd43: q = x / 64'sd43;
      6'd45: q = x / 64'sd45;
      6'd47: q = x / 64'sd47;
      6'd49: q = x / 64'sd49;
      6'd51: q = x / 64'sd51;
      6'd53: q = x / 64'sd53;
      6'd55: q = x / 64'sd55;
      6'd57: q = x / 64'sd57;
      6'd59: q = x / 64'sd59;
      6'd61: q = x / 64'sd61;
      default: q = x;
    endcase
    return q;
  endfunction

  // ln y for y in [1, 2], atanh series
  function automatic longint fx_ln_core(longint y);
    longint s;
    longint s2;
    longint term;
    longint sum;
    int     n;
    s    = fx_div(64'(y - One), 64'(y + One));
    s2   = fx_mul(s, s);
    term = s;
    sum  = 0;
    for (n = 1; n <= 61; n += 2) begin
      sum  = sum + fx_div_small(term, 6'(n));
      term = fx_mul(term, s2);
    end
    return 2 * sum;
  endfunction

  function automatic longint fx_ln(longint x_in, longint ln2q);
    longint x;
    longint e;
    x = x_in;
    e = 0;
    if (x <= 0) return 0;
    while (x > 2 * One) begin
      x = x >>> 1;
      e = e + 1;
    end
    while (x < One) begin
      x = x <<< 1;
      e = e - 1;
    end
    return fx_ln_core(x) + e * ln2q;
  endfunction

  // exp(-v) for v >= 0
  function automatic longint fx_exp_neg(longint v, longint ln2q);
    longint      k;
    longint      r;
    longint      term;
    longint      sum;
    logic [63:0] us;
    int          n;
    k = 0;
    r = v;
    while (r >= ln2q) begin
      r = r - ln2q;
      k = k + 1;
    end
    term = One;
    sum  = One;
    for (n = 1; n <= 30; n++) begin
      term = fx_div_small(fx_mul(term, r), 6'(n));
      sum  = n[0] ? sum - term : sum + term;
    end
    if (k >= 63) return 0;
    us = sum;
    us = us >> k;
    return $signed(us);
  endfunction

  function automatic longint fx_slope(longint t, longint m);
    return fx_mul(t, m) - One;
  endfunction

  // RK4 on m' = t m - 1, walking t down to target
  function automatic ode_t fx_descend(longint t0, longint m0, longint target);
    longint t;
    longint m;
    longint h;
    longint hh;
    longint k1;
    longint k2;
    longint k3;
    longint k4;
    ode_t   res;
    int     blk;
    int     j;
    t = t0;
    m = m0;
    for (blk = 0; blk < 64 && t > target; blk++) begin
      for (j = 0; j < 64 && t > target; j++) begin
        h = t - target;
        if (h > OdeStep) h = OdeStep;
        hh = h / 64'sd2;
        k1 = fx_slope(t, m);
        k2 = fx_slope(t - hh, m - fx_mul(hh, k1));
        k3 = fx_slope(t - hh, m - fx_mul(hh, k2));
        k4 = fx_slope(t - h, m - fx_mul(h, k3));
        m  = m - fx_mul(h, k1 + 2 * k2 + 2 * k3 + k4) / 64'sd6;
        t  = t - h;
      end
    end
    res.t = t;
    res.m = m;
    return res;
  endfunction

  // Round to Q.12, half away from zero
  function automatic logic [31:0] fx_to_q12(longint v);
    logic [63:0] r;
    r = (fx_mag(v) + (64'd1 << (Frac - 13))) >> (Frac - 12);
    if (v < 0) r = 64'd0 - r;
    return r[31:0];
  endfunction

endpackage

// File: design/pll_ram.sv
`timescale 1ns / 1ps

module pll_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/pll_lphi_rom.sv
`timescale 1ns / 1ps

module pll_lphi_rom
  import pll_pkg::*;
#(
  parameter int unsigned Entries = 1024,
  parameter int unsigned AddrW   = $clog2(Entries)
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [AddrW-1:0]      addr_i,
  output logic signed [LlW-1:0] data_o
);

  typedef logic [Entries-1:0][LlW-1:0] rom_t;

  // log Phi at bin centers over [-8, 8), Q7.12. Lower half from the
  // Mills ratio tail, upper half through 1 - Phi(-t).
  function automatic rom_t build_table();
    rom_t   tbl;
    longint ln2q;
    longint t;
    longint m;
    longint m0;
    longint lnm0;
    longint ti;
    longint half;
    longint e;
    longint q;
    ode_t   st;
    int     blk;
    int     j;
    int     i;
    tbl  = '0;
    ln2q = fx_ln_core(2 * One);
    st   = fx_descend(12 * One, One / 12, 0);
    m0   = st.m;
    lnm0 = fx_ln(m0, ln2q);
    t    = 12 * One;
    m    = One / 12;
    for (blk = 0; blk < 64; blk++) begin
      for (j = 0; j < 64; j++) begin
        i = blk * 64 + j;
        if (2 * i + 1 <= Entries) begin
          ti   = (longint'(Entries - 1 - 2 * i) <<< 43) / Entries;
          st   = fx_descend(t, m, ti);
          t    = st.t;
          m    = st.m;
          half = fx_mul(ti, ti) / 64'sd2;
          tbl[i] = LlW'(fx_to_q12(-half + fx_ln(m, ln2q) - ln2q - lnm0));
          e    = fx_exp_neg(half, ln2q);
          q    = fx_div(64'(fx_mul(e, m)), 64'(2 * m0));
          tbl[Entries - 1 - i] = LlW'(fx_to_q12(fx_ln(One - q, ln2q)));
        end
      end
    end
    return tbl;
  endfunction

  localparam rom_t RomTable = build_table();

  logic [LlW-1:0] rd_q;

  // Registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q <= RomTable[addr_i];
    end
  end

  assign data_o = $signed(rd_q);

endmodule

// File: design/probit_log_likelihood_accumulator.sv
`timescale 1ns / 1ps

// Probit log-likelihood accumulator.
// Input channel (in_valid_i / in_ready_o): load items (op 1) write a Q4.12
// coefficient into slot coef_index; data items (op 0) carry one feature each.
// The n-th feature of an observation is multiplied by coefficient n and summed.
// On the last feature (count reaches num_features) the block looks up
// log Phi(z) or log Phi(-z) by obs_label and emits one item on the output
// channel (out_valid_o / out_ready_i): obs_loglike, the saturating batch_total
// and batch_done, a copy of last_obs; the total clears after such an item.
// Config channel (cfg_valid_i / cfg_ready_o) writes num_features; it is always ready.
// The user must write it only while the block is idle; the block does not enforce this.
// Throughput: one item per cycle while the output is not stalled. Path: the
// coefficient read register loads with the item, then the multiply, accumulate,
// table read and total add registers follow in that order.
// Reset: num_features is 1, counts and sums are zero, coefficients are
// undefined until loaded; no startup pass.
// Receiver stall: the result stays in the output register; items keep
// entering until the internal stages behind it are full.
module probit_log_likelihood_accumulator
  import pll_pkg::*;
#(
  parameter int unsigned MaxFeatures  = 64,
  parameter int unsigned TableEntries = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [NfW-1:0]         cfg_data_i,
  // input items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  op_e                    op_i,
  input  logic [CoefIdxW-1:0]    coef_index_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic                   obs_label_i,
  input  logic                   last_obs_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [LlW-1:0]  obs_loglike_o,
  output logic signed [TotW-1:0] batch_total_o,
  output logic                   batch_done_o
);

  localparam int unsigned AddrW = (MaxFeatures > 1) ? $clog2(MaxFeatures) : 1;
  localparam int unsigned CntW  = $clog2(MaxFeatures + 1);
  localparam int unsigned CmpW  = (CntW > NfW) ? CntW : NfW;
  localparam int unsigned SlotW = (CntW > CoefIdxW) ? CntW : CoefIdxW;
  localparam int unsigned RomAW = $clog2(TableEntries);
  localparam int unsigned IdxPW = ZW + $clog2(TableEntries + 1);
  localparam int unsigned ZFullW = AccW - ZShift;

  // Control state
  logic [NfW-1:0]          nf_q;
  logic [CntW-1:0]         fc_q, fc_d;
  logic signed [AccW-1:0]  acc_q;
  logic signed [TotW-1:0]  tot_q, tot_d;

  // Pipeline stages
  logic                    s1_v_q, s1_end_q, s1_label_q, s1_last_q;
  logic signed [ValueW-1:0] s1_value_q;
  logic                    s2_v_q, s2_end_q, s2_label_q, s2_last_q;
  logic signed [ProdW-1:0] s2_prod_q;
  logic                    s3_v_q, s3_label_q, s3_last_q;
  logic signed [AccW-1:0]  s3_acc_q;
  logic                    s4_v_q, s4_last_q;
  logic                    out_valid_q, out_done_q;
  logic signed [LlW-1:0]   out_ll_q;
  logic signed [TotW-1:0]  out_tot_q;

  // Handshake and stage movement
  logic in_fire, data_fire, coef_we;
  logic out_free, s4_adv, s4_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free;

  assign out_free = ~out_valid_q | out_ready_i;
  assign s4_adv   = s4_v_q & out_free;
  assign s4_free  = ~s4_v_q | s4_adv;
  assign s3_adv   = s3_v_q & s4_free;
  assign s3_free  = ~s3_v_q | s3_adv;
  assign s2_adv   = s2_v_q & (~s2_end_q | s3_free);
  assign s2_free  = ~s2_v_q | s2_adv;
  assign s1_adv   = s1_v_q & s2_free;
  assign s1_free  = ~s1_v_q | s1_adv;

  assign in_ready_o  = s1_free;
  assign cfg_ready_o = 1'b1;

  assign in_fire   = in_valid_i & in_ready_o;
  assign data_fire = in_fire & (op_i == OpData);
  assign coef_we   = in_fire & (op_i == OpLoad) &
                     (SlotW'(coef_index_i) < SlotW'(MaxFeatures));

  // Feature position and end-of-observation detect
  logic [CmpW-1:0] nf_ext, eff, cnt_next;
  logic            obs_end;

  always_comb begin
    nf_ext = CmpW'(nf_q);
    if (nf_q == '0) begin
      eff = CmpW'(1);
    end else if (nf_ext > CmpW'(MaxFeatures)) begin
      eff = CmpW'(MaxFeatures);
    end else begin
      eff = nf_ext;
    end
    cnt_next = CmpW'(fc_q) + CmpW'(1);
    obs_end  = (cnt_next >= eff);
    fc_d     = obs_end ? '0 : CntW'(cnt_next);
  end

  // Coefficient store
  logic [ValueW-1:0] coef_rdata;

  pll_ram #(
    .Width (ValueW),
    .Depth (MaxFeatures),
    .AddrW (AddrW)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (AddrW'(coef_index_i)),
    .wdata_i (value_i),
    .re_i    (data_fire),
    .raddr_i (fc_q[AddrW-1:0]),
    .rdata_o (coef_rdata)
  );

  // Stage 1: feature times coefficient
  logic signed [ProdW-1:0] s1_prod;
  assign s1_prod = ProdW'(s1_value_q) * ProdW'($signed(coef_rdata));

  // Stage 2: saturating accumulate
  logic signed [AccSumW-1:0] acc_sum;
  logic signed [AccW-1:0]    acc_d;

  always_comb begin
    acc_sum = AccSumW'(acc_q) + AccSumW'(s2_prod_q);
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_d = {acc_sum[AccW], {(AccW-1){~acc_sum[AccW]}}};
    end else begin
      acc_d = acc_sum[AccW-1:0];
    end
  end

  // Stage 3: z = floor(acc / 4096), saturate, sign by label, table index
  logic signed [ZFullW-1:0] z_full;
  logic                     z_fits;
  logic signed [ZW-1:0]     z_sat, z_lbl;
  logic [ZW-1:0]            z_off;
  logic [IdxPW-1:0]         idx_prod;
  logic [RomAW-1:0]         rom_addr;

  always_comb begin
    z_full   = s3_acc_q[AccW-1:ZShift];
    z_fits   = (&z_full[ZFullW-1:ZW-1]) | ~(|z_full[ZFullW-1:ZW-1]);
    if (z_fits) begin
      z_sat = z_full[ZW-1:0];
    end else begin
      z_sat = z_full[ZFullW-1] ? ZMin : ZMax;
    end
    if (s3_label_q) begin
      z_lbl = z_sat;
    end else begin
      z_lbl = (z_sat == ZMin) ? ZMax : -z_sat;
    end
    z_off    = {~z_lbl[ZW-1], z_lbl[ZW-2:0]};
    idx_prod = IdxPW'(z_off) * IdxPW'(TableEntries);
    rom_addr = idx_prod[ZW +: RomAW];
  end

  logic signed [LlW-1:0] rom_ll;

  pll_lphi_rom #(
    .Entries (TableEntries),
    .AddrW   (RomAW)
  ) u_lphi_rom (
    .clk_i  (clk_i),
    .en_i   (s3_adv),
    .addr_i (rom_addr),
    .data_o (rom_ll)
  );

  // Stage 4: saturating running total
  logic signed [TotSumW-1:0] tot_sum;
  logic signed [TotW-1:0]    tot_sat;

  always_comb begin
    tot_sum = TotSumW'(tot_q) + TotSumW'(rom_ll);
    if (tot_sum[TotW] != tot_sum[TotW-1]) begin
      tot_sat = {tot_sum[TotW], {(TotW-1){~tot_sum[TotW]}}};
    end else begin
      tot_sat = tot_sum[TotW-1:0];
    end
    tot_d = s4_last_q ? '0 : tot_sat;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q        <= NfW'(1);
      fc_q        <= '0;
      acc_q       <= '0;
      tot_q       <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        nf_q <= cfg_data_i;
      end
      if (data_fire) begin
        fc_q <= fc_d;
      end
      if (s2_adv) begin
        acc_q <= s2_end_q ? '0 : acc_d;
      end
      if (s4_adv) begin
        tot_q <= tot_d;
      end
      if (data_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv && s2_end_q) begin
        s3_v_q <= 1'b1;
      end else if (s3_adv) begin
        s3_v_q <= 1'b0;
      end
      if (s3_adv) begin
        s4_v_q <= 1'b1;
      end else if (s4_adv) begin
        s4_v_q <= 1'b0;
      end
      if (s4_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (data_fire) begin
      s1_value_q <= value_i;
      s1_end_q   <= obs_end;
      s1_label_q <= obs_label_i;
      s1_last_q  <= last_obs_i;
    end
    if (s1_adv) begin
      s2_prod_q  <= s1_prod;
      s2_end_q   <= s1_end_q;
      s2_label_q <= s1_label_q;
      s2_last_q  <= s1_last_q;
    end
    if (s2_adv && s2_end_q) begin
      s3_acc_q   <= acc_d;
      s3_label_q <= s2_label_q;
      s3_last_q  <= s2_last_q;
    end
    if (s3_adv) begin
      s4_last_q <= s3_last_q;
    end
    if (s4_adv) begin
      out_ll_q   <= rom_ll;
      out_tot_q  <= tot_sat;
      out_done_q <= s4_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign obs_loglike_o = out_ll_q;
  assign batch_total_o = out_tot_q;
  assign batch_done_o  = out_done_q;

endmodule
